// ===== hw/rtl/spau_pkg.sv =====
// Shared types, constants and the size table for the sprite pixel address unit.
`timescale 1ns / 1ps

package spau_pkg;

  localparam int SCREEN_W_DEF       = 240;
  localparam int OBJ_VRAM_BYTES_DEF = 32768;

  localparam logic [9:0] X_WRAP   = 10'd512;
  localparam logic [7:0] Y_WRAP   = 8'd160;
  localparam logic [9:0] Y_SPAN   = 10'd256;
  localparam logic [9:0] TILE_BMP = 10'd512;
  localparam logic [5:0] ROW_2D   = 6'd32;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJ_MAPPING_1D = 2'd0,
    CFG_BITMAP_MODE    = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    NIB_BYTE = 2'd0,
    NIB_LOW  = 2'd1,
    NIB_HIGH = 2'd2
  } nib_sel_e;

  typedef struct packed {
    logic        obj_mapping_1d;
    logic        bitmap_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        attr_zero;
    logic [15:0]        attr_one;
    logic [15:0]        attr_two;
    logic [7:0]         scanline;
    logic [6:0]         column;
    logic signed [15:0] rot_a;
    logic signed [15:0] rot_b;
    logic signed [15:0] rot_c;
    logic signed [15:0] rot_d;
  } in_t;

  typedef struct packed {
    logic        covered;
    logic [7:0]  screen_x;
    logic [14:0] obj_vram_address;
    logic [1:0]  nibble_select;
    logic [1:0]  draw_priority;
    logic [3:0]  palette_bank;
    logic        full_color;
  } out_t;

  typedef struct packed {
    logic [6:0] w;
    logic [6:0] h;
  } size_t;

  typedef struct packed {
    logic               kill;
    logic               affine;
    logic               deep;
    logic [6:0]         w;
    logic [6:0]         h;
    logic [5:0]         tx_lin;
    logic [5:0]         ty_lin;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic signed [15:0] rot_a;
    logic signed [15:0] rot_b;
    logic signed [15:0] rot_c;
    logic signed [15:0] rot_d;
    logic [7:0]         screen_x;
    logic [9:0]         tile;
    logic [1:0]         prio;
    logic [3:0]         pal;
  } s1_t;

  typedef struct packed {
    logic               kill;
    logic               affine;
    logic               deep;
    logic [6:0]         w;
    logic [6:0]         h;
    logic [5:0]         tx_lin;
    logic [5:0]         ty_lin;
    logic signed [23:0] prod_a;
    logic signed [23:0] prod_b;
    logic signed [23:0] prod_c;
    logic signed [23:0] prod_d;
    logic [7:0]         screen_x;
    logic [9:0]         tile;
    logic [1:0]         prio;
    logic [3:0]         pal;
  } s2_t;

  typedef struct packed {
    logic       kill;
    logic       deep;
    logic [6:0] w;
    logic [5:0] tx;
    logic [5:0] ty;
    logic [7:0] screen_x;
    logic [9:0] tile;
    logic [1:0] prio;
    logic [3:0] pal;
  } s3_t;

  function automatic size_t obj_size(input logic [1:0] shape, input logic [1:0] sz);
    size_t s;
    unique case ({shape, sz})
      4'b00_00: s = '{w: 7'd8,  h: 7'd8};
      4'b00_01: s = '{w: 7'd16, h: 7'd16};
      4'b00_10: s = '{w: 7'd32, h: 7'd32};
      4'b00_11: s = '{w: 7'd64, h: 7'd64};
      4'b01_00: s = '{w: 7'd16, h: 7'd8};
      4'b01_01: s = '{w: 7'd32, h: 7'd8};
      4'b01_10: s = '{w: 7'd32, h: 7'd16};
      4'b01_11: s = '{w: 7'd64, h: 7'd32};
      4'b10_00: s = '{w: 7'd8,  h: 7'd16};
      4'b10_01: s = '{w: 7'd8,  h: 7'd32};
      4'b10_10: s = '{w: 7'd16, h: 7'd32};
      4'b10_11: s = '{w: 7'd32, h: 7'd64};
      default:  s = '{w: 7'd8,  h: 7'd8};
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/spau_decode.sv =====
// First pipeline stage: attribute decode, position wrap and line, column and screen checks.
`timescale 1ns / 1ps

module spau_decode import spau_pkg::*; #(
  parameter int SCREEN_W = SCREEN_W_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s1_t  data_o
);

  localparam logic [9:0] ScreenW = 10'(SCREEN_W);

  logic               valid_q;
  s1_t                data_q;
  s1_t                data_d;
  size_t              sz;
  logic               affine;
  logic               bit9;
  logic [1:0]         shape;
  logic [8:0]         x_raw;
  logic [7:0]         y_raw;
  logic signed [10:0] ox;
  logic signed [9:0]  oy;
  logic signed [9:0]  ly;
  logic signed [10:0] sx;
  logic [7:0]         rw;
  logic [7:0]         rh;
  logic signed [8:0]  dx_full;
  logic signed [9:0]  dy_full;
  logic [6:0]         tx_flip;
  logic [6:0]         ty_flip;
  logic               line_ok;
  logic               col_ok;
  logic               sx_ok;
  logic               bad;

  always_comb begin
    affine = data_i.attr_zero[8];
    bit9   = data_i.attr_zero[9];
    shape  = data_i.attr_zero[15:14];
    sz     = obj_size(shape, data_i.attr_one[15:14]);
    x_raw  = data_i.attr_one[8:0];
    y_raw  = data_i.attr_zero[7:0];

    if ({1'b0, x_raw} >= ScreenW) begin
      ox = $signed({2'b00, x_raw}) - $signed({1'b0, X_WRAP});
    end else begin
      ox = $signed({2'b00, x_raw});
    end
    if (y_raw >= Y_WRAP) begin
      oy = $signed({2'b00, y_raw}) - $signed(Y_SPAN);
    end else begin
      oy = $signed({2'b00, y_raw});
    end

    rw = (affine && bit9) ? {sz.w, 1'b0} : {1'b0, sz.w};
    rh = (affine && bit9) ? {sz.h, 1'b0} : {1'b0, sz.h};

    ly      = $signed({2'b00, data_i.scanline}) - oy;
    line_ok = !ly[9] && (ly < $signed({2'b00, rh}));
    col_ok  = {1'b0, data_i.column} < rw;
    sx      = ox + $signed({4'b0000, data_i.column});
    sx_ok   = !sx[10] && (sx[9:0] < ScreenW);

    dx_full = $signed({2'b00, data_i.column}) - $signed({2'b00, rw[7:1]});
    dy_full = ly - $signed({3'b000, rh[7:1]});
    tx_flip = sz.w - 7'd1 - data_i.column;
    ty_flip = sz.h - 7'd1 - ly[6:0];

    bad = (!affine && bit9) || (shape == 2'd3)
        || (cfg_i.bitmap_mode && (data_i.attr_two[9:0] < TILE_BMP))
        || !line_ok || !col_ok || !sx_ok;

    data_d.kill     = bad;
    data_d.affine   = affine;
    data_d.deep     = data_i.attr_zero[13];
    data_d.w        = sz.w;
    data_d.h        = sz.h;
    data_d.tx_lin   = data_i.attr_one[12] ? tx_flip[5:0] : data_i.column[5:0];
    data_d.ty_lin   = data_i.attr_one[13] ? ty_flip[5:0] : ly[5:0];
    data_d.dx       = dx_full[7:0];
    data_d.dy       = dy_full[7:0];
    data_d.rot_a    = data_i.rot_a;
    data_d.rot_b    = data_i.rot_b;
    data_d.rot_c    = data_i.rot_c;
    data_d.rot_d    = data_i.rot_d;
    data_d.screen_x = sx[7:0];
    data_d.tile     = data_i.attr_two[9:0];
    data_d.prio     = data_i.attr_two[11:10];
    data_d.pal      = data_i.attr_two[15:12];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hw/rtl/spau_affine.sv =====
// Second and third pipeline stages: affine products, then texel coordinates and texture bounds.
`timescale 1ns / 1ps

module spau_affine import spau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s3_t  data_o
);

  logic               mul_valid_q;
  s2_t                mul_q;
  s2_t                mul_d;
  logic               mul_ready;
  logic               tex_valid_q;
  s3_t                tex_q;
  s3_t                tex_d;
  logic signed [24:0] sum_x;
  logic signed [24:0] sum_y;
  logic signed [17:0] tx_w;
  logic signed [17:0] ty_w;
  logic               tex_ok;

  always_comb begin
    mul_d.kill     = data_i.kill;
    mul_d.affine   = data_i.affine;
    mul_d.deep     = data_i.deep;
    mul_d.w        = data_i.w;
    mul_d.h        = data_i.h;
    mul_d.tx_lin   = data_i.tx_lin;
    mul_d.ty_lin   = data_i.ty_lin;
    mul_d.prod_a   = data_i.rot_a * data_i.dx;
    mul_d.prod_b   = data_i.rot_b * data_i.dy;
    mul_d.prod_c   = data_i.rot_c * data_i.dx;
    mul_d.prod_d   = data_i.rot_d * data_i.dy;
    mul_d.screen_x = data_i.screen_x;
    mul_d.tile     = data_i.tile;
    mul_d.prio     = data_i.prio;
    mul_d.pal      = data_i.pal;
  end

  // The arithmetic shift of the sum floors the 8.8 result towards minus infinity.
  always_comb begin
    sum_x  = $signed({mul_q.prod_a[23], mul_q.prod_a})
           + $signed({mul_q.prod_b[23], mul_q.prod_b});
    sum_y  = $signed({mul_q.prod_c[23], mul_q.prod_c})
           + $signed({mul_q.prod_d[23], mul_q.prod_d});
    tx_w   = $signed({sum_x[24], sum_x[24:8]}) + $signed({12'd0, mul_q.w[6:1]});
    ty_w   = $signed({sum_y[24], sum_y[24:8]}) + $signed({12'd0, mul_q.h[6:1]});
    tex_ok = !tx_w[17] && (tx_w < $signed({11'd0, mul_q.w}))
          && !ty_w[17] && (ty_w < $signed({11'd0, mul_q.h}));

    tex_d.kill     = mul_q.kill || (mul_q.affine && !tex_ok);
    tex_d.deep     = mul_q.deep;
    tex_d.w        = mul_q.w;
    tex_d.tx       = mul_q.affine ? tx_w[5:0] : mul_q.tx_lin;
    tex_d.ty       = mul_q.affine ? ty_w[5:0] : mul_q.ty_lin;
    tex_d.screen_x = mul_q.screen_x;
    tex_d.tile     = mul_q.tile;
    tex_d.prio     = mul_q.prio;
    tex_d.pal      = mul_q.pal;
  end

  assign mul_ready = !tex_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;
  assign valid_o   = tex_valid_q;
  assign data_o    = tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      tex_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (mul_ready) begin
        tex_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mul_q <= mul_d;
    end
    if (mul_valid_q && mul_ready) begin
      tex_q <= tex_d;
    end
  end

endmodule

// ===== hw/rtl/spau_address.sv =====
// Fourth pipeline stage and output register: tile mapping, byte address and range check.
`timescale 1ns / 1ps

module spau_address import spau_pkg::*; #(
  parameter int OBJ_VRAM_BYTES = OBJ_VRAM_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  s3_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  localparam logic [16:0] VramLimit = 17'(OBJ_VRAM_BYTES);

  logic        valid_q;
  out_t        data_q;
  out_t        data_d;
  logic [5:0]  row;
  logic [10:0] row_off;
  logic [10:0] col_off;
  logic [10:0] tile;
  logic [5:0]  pix_off;
  logic [15:0] addr;
  logic        hit;

  always_comb begin
    if (cfg_i.obj_mapping_1d) begin
      row = data_i.deep ? {1'b0, data_i.w[6:3], 1'b0} : {2'b00, data_i.w[6:3]};
    end else begin
      row = ROW_2D;
    end
    row_off = {8'd0, data_i.ty[5:3]} * {5'd0, row};
    col_off = data_i.deep ? {7'd0, data_i.tx[5:3], 1'b0} : {8'd0, data_i.tx[5:3]};
    tile    = {1'b0, data_i.tile} + row_off + col_off;
    pix_off = data_i.deep ? {data_i.ty[2:0], data_i.tx[2:0]}
                          : {1'b0, data_i.ty[2:0], data_i.tx[2:1]};
    addr    = {tile, 5'd0} + {10'd0, pix_off};
    hit     = !data_i.kill && ({1'b0, addr} < VramLimit);

    data_d = '0;
    if (hit) begin
      data_d.covered          = 1'b1;
      data_d.screen_x         = data_i.screen_x;
      data_d.obj_vram_address = addr[14:0];
      if (data_i.deep) begin
        data_d.nibble_select = NIB_BYTE;
      end else if (data_i.tx[0]) begin
        data_d.nibble_select = NIB_HIGH;
      end else begin
        data_d.nibble_select = NIB_LOW;
      end
      data_d.draw_priority    = data_i.prio;
      data_d.palette_bank     = data_i.pal;
      data_d.full_color       = data_i.deep;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hw/rtl/sprite_pixel_address_unit.sv =====
// Top level of the sprite pixel address unit: configuration registers and the four-stage pipeline.
//
// Each input beat carries one sprite's three attribute words, its four affine
// parameters, the scanline and a column within the sprite's rendered width. Each
// beat yields exactly one output beat: whether the column fetches a texel, the
// screen column, the byte address in object tile memory, the nibble select,
// priority, palette bank and the 8bpp flag. A column that is not covered gives
// an output beat with every field zero.
// The pipeline has four register stages: decode, affine products, texel
// coordinates, and address with the output register. Unless the output stalls,
// one beat is accepted per cycle.
// Each stage keeps its own valid bit, so a stalled receiver fills the bubbles
// first; in_ready_o falls only when all four stages hold a beat and the output
// is not taken. Nothing is dropped or repeated under stalls.
// The configuration channel is always ready; index 0 selects linear tile mapping
// and index 1 the bitmap display modes. Write it only while the pipeline is empty.
// Reset empties the pipeline and clears both configuration bits.
`timescale 1ns / 1ps

module sprite_pixel_address_unit import spau_pkg::*; #(
  parameter int SCREEN_W       = SCREEN_W_DEF,
  parameter int OBJ_VRAM_BYTES = OBJ_VRAM_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  cfg_t cfg_q;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s3_valid;
  logic s3_ready;
  s3_t  s3_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OBJ_MAPPING_1D: cfg_q.obj_mapping_1d <= cfg_data_i;
        CFG_BITMAP_MODE:    cfg_q.bitmap_mode    <= cfg_data_i;
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  spau_decode #(
    .SCREEN_W (SCREEN_W)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  spau_affine u_affine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  spau_address #(
    .OBJ_VRAM_BYTES (OBJ_VRAM_BYTES)
  ) u_address (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.covered |->
      out_data_o.screen_x == '0 && out_data_o.obj_vram_address == '0 &&
      out_data_o.nibble_select == '0 && out_data_o.draw_priority == '0 &&
      out_data_o.palette_bank == '0 && !out_data_o.full_color)
    else $error("uncovered beat carries non-zero fields");

  a_nibble_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.covered |->
      ((out_data_o.nibble_select == NIB_BYTE) == out_data_o.full_color) &&
      (out_data_o.nibble_select != 2'd3))
    else $error("nibble select disagrees with colour depth");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the pipeline has room");

endmodule
